@@ hdl/evr_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// evr_pkg
// Shared constants, types and wide multiply helpers for the velocity rotator.
// ----------------------------------------------------------------------------
package evr_pkg;

	localparam int VEL_WIDTH_DEF = 32;
	localparam int TRIG_FRAC_DEF = 30;

	// internal series arithmetic runs in unsigned Q60
	localparam int SER_STEPS = 12;
	localparam logic [63:0] HALF_PI_Q60 = 64'h1921_FB54_442D_1847;
	localparam logic [63:0] ONE_Q60 = 64'h1000_0000_0000_0000;

	// fold (5) + series steps (5 each) + final rounding (1)
	localparam int TRIG_LAT = 5 + 5 * SER_STEPS + 1;

	typedef enum logic {
		OP_TO_VIEW   = 1'b0,
		OP_FROM_VIEW = 1'b1
	} op_t;

	// four 32x32 partial products of a 64x64 multiply
	typedef struct packed {
		logic [63:0] p00;
		logic [63:0] p01;
		logic [63:0] p10;
		logic [63:0] p11;
	} part_t;

	// running state of the sine and cosine series
	typedef struct packed {
		logic [63:0] th2;
		logic [63:0] s;
		logic [63:0] st;
		logic [63:0] c;
		logic [63:0] ct;
		logic [1:0]  quad;
		logic        swap;
	} ser_t;

	function automatic part_t part_mul(input logic [63:0] a, input logic [63:0] b);
		part_t p;
		p.p00 = 64'(a[31:0]) * 64'(b[31:0]);
		p.p01 = 64'(a[31:0]) * 64'(b[63:32]);
		p.p10 = 64'(a[63:32]) * 64'(b[31:0]);
		p.p11 = 64'(a[63:32]) * 64'(b[63:32]);
		return p;
	endfunction

	function automatic logic [127:0] part_sum(input part_t p);
		return {p.p11, 64'b0} + {32'b0, p.p01, 32'b0} + {32'b0, p.p10, 32'b0}
			+ {64'b0, p.p00};
	endfunction

endpackage
`default_nettype wire

@@ hdl/evr_trig.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// evr_trig
// Pipelined sine and cosine of a binary angle: octant fold, Q60 Taylor series
// one term per five stages, rounding to Q(TRIG_FRAC_BITS).
// ----------------------------------------------------------------------------
module evr_trig #(
	parameter int TRIG_FRAC_BITS = evr_pkg::TRIG_FRAC_DEF
) (
	input  wire                              clk,
	input  wire                              adv,
	input  wire  [31:0]                      angle,
	output logic signed [TRIG_FRAC_BITS+1:0] sin_val,
	output logic signed [TRIG_FRAC_BITS+1:0] cos_val
);

	localparam int SH = 60 - TRIG_FRAC_BITS;
	localparam logic [63:0] RND = 64'd1 << (SH - 1);
	localparam logic [127:0] TWO64 = 128'd1 << 64;

	// fold front end
	logic [29:0]        x_s1;
	logic [1:0]         quad_s1, quad_s2, quad_s3, quad_s4, quad_s5;
	logic               swap_s1, swap_s2, swap_s3, swap_s4, swap_s5;
	evr_pkg::part_t     part_s2, part_s4;
	logic [63:0]        th_s3, th_s4, th_s5, th2_s5;
	logic [29:0]        r_in;
	logic               swap_in;

	evr_pkg::ser_t      ser_w [0:evr_pkg::SER_STEPS];

	assign r_in = angle[29:0];
	assign swap_in = (r_in > 30'h2000_0000);

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s1    <= swap_in ? 30'(31'h4000_0000 - 31'(r_in)) : r_in;
			quad_s1 <= angle[31:30];
			swap_s1 <= swap_in;

			part_s2 <= evr_pkg::part_mul(64'(x_s1), evr_pkg::HALF_PI_Q60);
			quad_s2 <= quad_s1;
			swap_s2 <= swap_s1;

			th_s3   <= 64'(evr_pkg::part_sum(part_s2) >> 30);
			quad_s3 <= quad_s2;
			swap_s3 <= swap_s2;

			part_s4 <= evr_pkg::part_mul(th_s3, th_s3);
			th_s4   <= th_s3;
			quad_s4 <= quad_s3;
			swap_s4 <= swap_s3;

			th2_s5  <= 64'(evr_pkg::part_sum(part_s4) >> 60);
			th_s5   <= th_s4;
			quad_s5 <= quad_s4;
			swap_s5 <= swap_s4;
		end
	end

	assign ser_w[0] = {th2_s5, th_s5, th_s5, evr_pkg::ONE_Q60, evr_pkg::ONE_Q60,
		quad_s5, swap_s5};

	for (genvar k = 1; k <= evr_pkg::SER_STEPS; k++) begin : g_step
		localparam int DS = (2 * k) * (2 * k + 1);
		localparam int DC = (2 * k - 1) * (2 * k);
		localparam logic [63:0] RS = 64'(TWO64 / 128'(DS));
		localparam logic [63:0] RC = 64'(TWO64 / 128'(DC));

		evr_pkg::ser_t  hold_s1, hold_s2, hold_s3, hold_s4, ser_s5, nxt;
		evr_pkg::part_t sp_s1, cp_s1, sp_s3, cp_s3;
		logic [63:0]    sn_s2, cn_s2, sn_s3, cn_s3, sn_s4, cn_s4, sq_s4, cq_s4;
		logic [63:0]    srem, crem, sq, cq;

		// term * th2, then quotient estimate by reciprocal, then one correction
		always_ff @(posedge clk) begin
			if (adv) begin
				hold_s1 <= ser_w[k-1];
				sp_s1   <= evr_pkg::part_mul(ser_w[k-1].st, ser_w[k-1].th2);
				cp_s1   <= evr_pkg::part_mul(ser_w[k-1].ct, ser_w[k-1].th2);

				hold_s2 <= hold_s1;
				sn_s2   <= 64'(evr_pkg::part_sum(sp_s1) >> 60);
				cn_s2   <= 64'(evr_pkg::part_sum(cp_s1) >> 60);

				hold_s3 <= hold_s2;
				sp_s3   <= evr_pkg::part_mul(sn_s2, RS);
				cp_s3   <= evr_pkg::part_mul(cn_s2, RC);
				sn_s3   <= sn_s2;
				cn_s3   <= cn_s2;

				hold_s4 <= hold_s3;
				sq_s4   <= 64'(evr_pkg::part_sum(sp_s3) >> 64);
				cq_s4   <= 64'(evr_pkg::part_sum(cp_s3) >> 64);
				sn_s4   <= sn_s3;
				cn_s4   <= cn_s3;

				ser_s5  <= nxt;
			end
		end

		always_comb begin
			srem = sn_s4 - 64'(sq_s4 * 64'(DS));
			crem = cn_s4 - 64'(cq_s4 * 64'(DC));
			sq = (srem >= 64'(DS)) ? sq_s4 + 64'd1 : sq_s4;
			cq = (crem >= 64'(DC)) ? cq_s4 + 64'd1 : cq_s4;
			nxt = hold_s4;
			nxt.st = sq;
			nxt.ct = cq;
			if ((k % 2) == 1) begin
				nxt.s = hold_s4.s - sq;
				nxt.c = hold_s4.c - cq;
			end else begin
				nxt.s = hold_s4.s + sq;
				nxt.c = hold_s4.c + cq;
			end
		end

		assign ser_w[k] = ser_s5;
	end

	// final rounding and quadrant signs
	evr_pkg::ser_t                     fin;
	logic [63:0]                       s_sum, c_sum;
	logic signed [TRIG_FRAC_BITS+1:0]  sr, cr, sin_nxt, cos_nxt;

	assign fin = ser_w[evr_pkg::SER_STEPS];

	always_comb begin
		s_sum = ((fin.swap ? fin.c : fin.s) + RND) >> SH;
		c_sum = ((fin.swap ? fin.s : fin.c) + RND) >> SH;
		sr = $signed({1'b0, s_sum[TRIG_FRAC_BITS:0]});
		cr = $signed({1'b0, c_sum[TRIG_FRAC_BITS:0]});
		case (fin.quad)
			2'd0: begin
				sin_nxt = sr;
				cos_nxt = cr;
			end
			2'd1: begin
				sin_nxt = cr;
				cos_nxt = -sr;
			end
			2'd2: begin
				sin_nxt = -sr;
				cos_nxt = -cr;
			end
			default: begin
				sin_nxt = -cr;
				cos_nxt = sr;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sin_val <= sin_nxt;
			cos_val <= cos_nxt;
		end
	end

endmodule
`default_nettype wire

@@ hdl/ecef_ned_velocity_rotator.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ecef_ned_velocity_rotator
// Rotates velocities between ECEF and local north-east-down at an origin.
// ----------------------------------------------------------------------------
// Usage:
//  - item channel (item_valid/item_ready) takes opcode, origin angles, origin
//    velocity and a second vector; result channel (result_valid/result_ready)
//    returns one rotated vector and a saturation flag per transaction.
//  - opcode to-view: (second - origin) clamped, rotated into NED.
//    opcode from-view: NED vector rotated into ECEF plus origin velocity.
//  - one transaction per cycle while the output register is not held.
//    Latency is set by the sine/cosine series, twelve Q60 terms of five
//    stages each (multiply, reciprocal divide, correction).
//  - the whole pipeline advances together; when the output register holds a
//    transaction the receiver has not taken, every stage holds and
//    item_ready drops, so nothing is lost or repeated.
//  - reset clears all valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
module ecef_ned_velocity_rotator #(
	parameter int VEL_WIDTH      = evr_pkg::VEL_WIDTH_DEF,
	parameter int TRIG_FRAC_BITS = evr_pkg::TRIG_FRAC_DEF
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         item_valid,
	output logic                        item_ready,
	input  wire                         opcode,
	input  wire  signed [31:0]          latitude,
	input  wire  signed [31:0]          longitude,
	input  wire  signed [VEL_WIDTH-1:0] origin_vx,
	input  wire  signed [VEL_WIDTH-1:0] origin_vy,
	input  wire  signed [VEL_WIDTH-1:0] origin_vz,
	input  wire  signed [VEL_WIDTH-1:0] second_a,
	input  wire  signed [VEL_WIDTH-1:0] second_b,
	input  wire  signed [VEL_WIDTH-1:0] second_c,
	output logic                        result_valid,
	input  wire                         result_ready,
	output logic signed [VEL_WIDTH-1:0] result_a,
	output logic signed [VEL_WIDTH-1:0] result_b,
	output logic signed [VEL_WIDTH-1:0] result_c,
	output logic                        saturated
);

	localparam int W   = VEL_WIDTH;
	localparam int F   = TRIG_FRAC_BITS;
	localparam int TW  = F + 2;
	localparam int PW  = 1 + 6 * W;
	localparam int MW  = TW + W;
	localparam int AW  = W + F + 4;
	localparam int LAT = evr_pkg::TRIG_LAT;

	localparam logic signed [W:0]    DMAX = $signed({2'b00, {(W-1){1'b1}}});
	localparam logic signed [W:0]    DMIN = $signed({2'b11, {(W-1){1'b0}}});
	localparam logic signed [W+3:0]  QMAX = $signed({5'b00000, {(W-1){1'b1}}});
	localparam logic signed [W+3:0]  QMIN = $signed({5'b11111, {(W-1){1'b0}}});
	localparam logic [2*TW-1:0]      CRND = (2*TW)'(1) << (F - 1);
	localparam logic signed [AW-1:0] ARND = $signed((AW)'(1) << (F - 1));
	localparam logic signed [TW-1:0] TONE = $signed({2'b01, {F{1'b0}}});

	logic adv;
	assign adv = !result_valid || result_ready;
	assign item_ready = adv;

	// trig units
	logic signed [TW-1:0] sl, cl, slo, clo;

	evr_trig #(.TRIG_FRAC_BITS(F)) u_trig_lat (
		.clk(clk), .adv(adv), .angle(latitude), .sin_val(sl), .cos_val(cl)
	);
	evr_trig #(.TRIG_FRAC_BITS(F)) u_trig_lon (
		.clk(clk), .adv(adv), .angle(longitude), .sin_val(slo), .cos_val(clo)
	);

	// payload delay line matching the trig latency
	logic [PW-1:0]  pay_s [0:LAT-1];
	logic [LAT-1:0] vld_s;
	logic [PW-1:0]  tap;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[LAT-2:0], item_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pay_s[0] <= {opcode, origin_vx, origin_vy, origin_vz, second_a, second_b, second_c};
			for (int i = 1; i < LAT; i++) begin
				pay_s[i] <= pay_s[i-1];
			end
		end
	end

	assign tap = pay_s[LAT-1];

	// stage 1: coefficient products, difference clamp
	logic signed [W-1:0]    org_in [3];
	logic signed [W-1:0]    sec_in [3];
	logic signed [W-1:0]    v_in [3];
	logic signed [W:0]      dif;
	logic                   sat_in;

	always_comb begin
		sat_in = 1'b0;
		for (int i = 0; i < 3; i++) begin
			org_in[i] = $signed(tap[(6-i)*W-1 -: W]);
			sec_in[i] = $signed(tap[(3-i)*W-1 -: W]);
			dif = $signed({sec_in[i][W-1], sec_in[i]}) - $signed({org_in[i][W-1], org_in[i]});
			if (tap[PW-1] == evr_pkg::OP_FROM_VIEW) begin
				v_in[i] = sec_in[i];
			end else if (dif > DMAX) begin
				v_in[i] = DMAX[W-1:0];
				sat_in = 1'b1;
			end else if (dif < DMIN) begin
				v_in[i] = DMIN[W-1:0];
				sat_in = 1'b1;
			end else begin
				v_in[i] = dif[W-1:0];
			end
		end
	end

	logic                   vld_s1, vld_s2, vld_s3, vld_s4;
	logic                   op_s1;
	logic                   sat_s1, sat_s2, sat_s3, sat_s4;
	logic signed [TW-1:0]   sl_s1, cl_s1, slo_s1, clo_s1;
	logic signed [2*TW-1:0] psc_s1, pss_s1, pcc_s1, pcs_s1;
	logic signed [W-1:0]    org_s1 [3];
	logic signed [W-1:0]    v_s1 [3];
	logic signed [W-1:0]    v_s2 [3];
	logic signed [TW-1:0]   coef_s2 [3][3];
	logic signed [AW-1:0]   init_s2 [3];
	logic signed [AW-1:0]   init_s3 [3];
	logic signed [MW-1:0]   prod_s3 [3][3];
	logic signed [AW-1:0]   acc_s4 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1       <= 1'b0;
			vld_s2       <= 1'b0;
			vld_s3       <= 1'b0;
			vld_s4       <= 1'b0;
			result_valid <= 1'b0;
		end else if (adv) begin
			vld_s1       <= vld_s[LAT-1];
			vld_s2       <= vld_s1;
			vld_s3       <= vld_s2;
			vld_s4       <= vld_s3;
			result_valid <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			op_s1  <= tap[PW-1];
			sat_s1 <= sat_in;
			sl_s1  <= sl;
			cl_s1  <= cl;
			slo_s1 <= slo;
			clo_s1 <= clo;
			psc_s1 <= (2*TW)'(sl) * (2*TW)'(clo);
			pss_s1 <= (2*TW)'(sl) * (2*TW)'(slo);
			pcc_s1 <= (2*TW)'(cl) * (2*TW)'(clo);
			pcs_s1 <= (2*TW)'(cl) * (2*TW)'(slo);
			for (int i = 0; i < 3; i++) begin
				org_s1[i] <= org_in[i];
				v_s1[i]   <= v_in[i];
			end
		end
	end

	// stage 2: rounded matrix, orientation by opcode
	function automatic logic signed [TW-1:0] coef_rnd(input logic signed [2*TW-1:0] p);
		logic [2*TW-1:0] mag;
		logic [2*TW-1:0] r;
		logic signed [TW-1:0] rv;
		mag = p[2*TW-1] ? (~p + 1'b1) : p;
		r = (mag + CRND) >> F;
		rv = $signed(r[TW-1:0]);
		return p[2*TW-1] ? -rv : rv;
	endfunction

	logic signed [TW-1:0] mat [3][3];

	always_comb begin
		mat[0][0] = -coef_rnd(psc_s1);
		mat[0][1] = -coef_rnd(pss_s1);
		mat[0][2] = cl_s1;
		mat[1][0] = -slo_s1;
		mat[1][1] = clo_s1;
		mat[1][2] = '0;
		mat[2][0] = -coef_rnd(pcc_s1);
		mat[2][1] = -coef_rnd(pcs_s1);
		mat[2][2] = -sl_s1;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sat_s2 <= sat_s1;
			for (int i = 0; i < 3; i++) begin
				v_s2[i] <= v_s1[i];
				if (op_s1 == evr_pkg::OP_FROM_VIEW) begin
					init_s2[i] <= $signed({{(AW-W){org_s1[i][W-1]}}, org_s1[i]}) <<< F;
				end else begin
					init_s2[i] <= '0;
				end
				for (int j = 0; j < 3; j++) begin
					coef_s2[i][j] <= (op_s1 == evr_pkg::OP_FROM_VIEW) ? mat[j][i] : mat[i][j];
				end
			end
		end
	end

	// stage 3: products
	always_ff @(posedge clk) begin
		if (adv) begin
			sat_s3 <= sat_s2;
			for (int i = 0; i < 3; i++) begin
				init_s3[i] <= init_s2[i];
				for (int j = 0; j < 3; j++) begin
					prod_s3[i][j] <= MW'(coef_s2[i][j]) * MW'(v_s2[j]);
				end
			end
		end
	end

	// stage 4: row sums with rounding offset
	always_ff @(posedge clk) begin
		if (adv) begin
			sat_s4 <= sat_s3;
			for (int i = 0; i < 3; i++) begin
				acc_s4[i] <= init_s3[i] + ARND
					+ $signed({{(AW-MW){prod_s3[i][0][MW-1]}}, prod_s3[i][0]})
					+ $signed({{(AW-MW){prod_s3[i][1][MW-1]}}, prod_s3[i][1]})
					+ $signed({{(AW-MW){prod_s3[i][2][MW-1]}}, prod_s3[i][2]});
			end
		end
	end

	// stage 5: scale, saturate, output register
	logic signed [W+3:0] q [3];
	logic signed [W-1:0] res [3];
	logic                sat_out;

	always_comb begin
		sat_out = sat_s4;
		for (int i = 0; i < 3; i++) begin
			q[i] = $signed(acc_s4[i][AW-1:F]);
			if (q[i] > QMAX) begin
				res[i] = QMAX[W-1:0];
				sat_out = 1'b1;
			end else if (q[i] < QMIN) begin
				res[i] = QMIN[W-1:0];
				sat_out = 1'b1;
			end else begin
				res[i] = q[i][W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			result_a  <= res[0];
			result_b  <= res[1];
			result_c  <= res[2];
			saturated <= sat_out;
		end
	end

	// checks
	a_stall_only_on_full: assert property (@(posedge clk) disable iff (!arst_n)
		!item_ready |-> (result_valid && !result_ready))
		else $error("input stalled without a blocked result");

	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result_ready) |=> ($stable(result_a) && $stable(result_b)
			&& $stable(result_c) && $stable(saturated)))
		else $error("blocked result changed");

	a_trig_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[LAT-1] |-> (sl <= TONE && sl >= -TONE && clo <= TONE && clo >= -TONE))
		else $error("trig value out of unit range");

	a_valid_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && vld_s4) |=> result_valid)
		else $error("pipeline dropped a transaction");

endmodule
`default_nettype wire

@@ tb/sv/ecef_ned_velocity_rotator_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ecef_ned_velocity_rotator_tb
// Drives directed and random rotations through the item channel with random
// gaps and result stalls, predicts every NED/ECEF vector and saturation flag
// in bit-exact fixed point, and compares each result transaction in order.
// ----------------------------------------------------------------------------
module ecef_ned_velocity_rotator_tb;

	localparam int VW = 32;
	localparam int TF = 30;

	typedef struct {
		evr_pkg::op_t         op;
		logic signed [31:0]   lat;
		logic signed [31:0]   lon;
		logic signed [VW-1:0] org [3];
		logic signed [VW-1:0] sec [3];
	} rot_item_t;

	typedef struct {
		logic [VW-1:0] v [3];
		logic          sat;
	} rot_vec_t;

	class rotation_board;
		rot_vec_t pending [$];
		int       errors;
		int       n_view;
		int       n_back;
		int       n_sat;
		int       n_checked;

		function new();
			errors = 0;
			n_view = 0;
			n_back = 0;
			n_sat = 0;
			n_checked = 0;
		endfunction

		// sine and cosine of a binary angle, Q30, by octant fold and series
		static function void sincos(input logic [31:0] ang, output longint so,
				output longint co);
			logic [1:0]   quad;
			logic [63:0]  r, x, th, th2, term, s, c, sr, cr;
			logic [127:0] p;
			logic         swap;
			quad = ang[31:30];
			r = {34'b0, ang[29:0]};
			swap = 1'b0;
			if (r > 64'd536870912) begin
				x = 64'd1073741824 - r;
				swap = 1'b1;
			end else begin
				x = r;
			end
			p = {64'b0, x} * {64'b0, 64'h1921FB54442D1847};
			th = p[93:30];
			p = {64'b0, th} * {64'b0, th};
			th2 = p[123:60];
			s = th;
			term = th;
			for (int k = 1; k <= 12; k++) begin
				p = {64'b0, term} * {64'b0, th2};
				term = p[123:60] / 64'((2 * k) * (2 * k + 1));
				if (k & 1) s = s - term; else s = s + term;
			end
			c = 64'h1000_0000_0000_0000;
			term = c;
			for (int k = 1; k <= 12; k++) begin
				p = {64'b0, term} * {64'b0, th2};
				term = p[123:60] / 64'((2 * k - 1) * (2 * k));
				if (k & 1) c = c - term; else c = c + term;
			end
			sr = ((swap ? c : s) + (64'd1 << 29)) >> 30;
			cr = ((swap ? s : c) + (64'd1 << 29)) >> 30;
			case (quad)
				2'd0: begin so = longint'(sr);  co = longint'(cr);  end
				2'd1: begin so = longint'(cr);  co = -longint'(sr); end
				2'd2: begin so = -longint'(sr); co = -longint'(cr); end
				default: begin so = -longint'(cr); co = longint'(sr); end
			endcase
		endfunction

		// trig product rounded back to Q30, ties away from zero
		static function longint coef(input longint a, input longint b);
			longint pr, mg, rr;
			pr = a * b;
			mg = (pr < 0) ? -pr : pr;
			rr = (mg + (longint'(1) << (TF - 1))) >>> TF;
			return (pr < 0) ? -rr : rr;
		endfunction

		static function logic [VW-1:0] round_sat(input logic signed [127:0] acc,
				inout logic sat);
			logic signed [127:0] t;
			t = (acc + (128'sd1 <<< (TF - 1))) >>> TF;
			if (t > 128'sd2147483647) begin
				sat = 1'b1;
				return 32'h7FFF_FFFF;
			end
			if (t < -128'sd2147483648) begin
				sat = 1'b1;
				return 32'h8000_0000;
			end
			return t[VW-1:0];
		endfunction

		static function rot_vec_t rotate(input rot_item_t it);
			longint              sl, cl, so, co;
			longint              m [3][3];
			longint              vv [3];
			longint              d;
			logic signed [127:0] acc, cc, xx;
			rot_vec_t            res;
			res.sat = 1'b0;
			sincos(it.lat, sl, cl);
			sincos(it.lon, so, co);
			m[0][0] = -coef(sl, co); m[0][1] = -coef(sl, so); m[0][2] = cl;
			m[1][0] = -so;           m[1][1] = co;            m[1][2] = 0;
			m[2][0] = -coef(cl, co); m[2][1] = -coef(cl, so); m[2][2] = -sl;
			for (int i = 0; i < 3; i++) begin
				if (it.op == evr_pkg::OP_TO_VIEW) begin
					d = longint'(it.sec[i]) - longint'(it.org[i]);
					if (d > 64'sd2147483647) begin
						d = 64'sd2147483647;
						res.sat = 1'b1;
					end else if (d < -64'sd2147483648) begin
						d = -64'sd2147483648;
						res.sat = 1'b1;
					end
					vv[i] = d;
				end else begin
					vv[i] = longint'(it.sec[i]);
				end
			end
			for (int i = 0; i < 3; i++) begin
				if (it.op == evr_pkg::OP_TO_VIEW) begin
					acc = '0;
				end else begin
					acc = it.org[i];
					acc = acc <<< TF;
				end
				for (int j = 0; j < 3; j++) begin
					cc = (it.op == evr_pkg::OP_TO_VIEW) ? m[i][j] : m[j][i];
					xx = vv[j];
					acc = acc + cc * xx;
				end
				res.v[i] = round_sat(acc, res.sat);
			end
			return res;
		endfunction

		function void note_item(input rot_item_t it);
			pending.push_back(rotate(it));
			if (it.op == evr_pkg::OP_TO_VIEW) n_view++; else n_back++;
		endfunction

		task report(input string what);
			$display("mismatch: %s", what);
			errors++;
		endtask

		task check_result(input logic [VW-1:0] a, input logic [VW-1:0] b,
				input logic [VW-1:0] c, input logic sat);
			rot_vec_t e;
			if (pending.size() == 0) begin
				report($sformatf("unexpected result %h %h %h", a, b, c));
				return;
			end
			e = pending.pop_front();
			n_checked++;
			if (e.sat) n_sat++;
			if (a !== e.v[0]) report($sformatf("result_a %h, want %h", a, e.v[0]));
			if (b !== e.v[1]) report($sformatf("result_b %h, want %h", b, e.v[1]));
			if (c !== e.v[2]) report($sformatf("result_c %h, want %h", c, e.v[2]));
			if (sat !== e.sat) report($sformatf("saturated %b, want %b", sat, e.sat));
		endtask
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 item_valid = 1'b0;
	logic                 item_ready;
	logic                 opcode = 1'b0;
	logic signed [31:0]   latitude = '0;
	logic signed [31:0]   longitude = '0;
	logic signed [VW-1:0] origin_vx = '0;
	logic signed [VW-1:0] origin_vy = '0;
	logic signed [VW-1:0] origin_vz = '0;
	logic signed [VW-1:0] second_a = '0;
	logic signed [VW-1:0] second_b = '0;
	logic signed [VW-1:0] second_c = '0;
	logic                 result_valid;
	logic                 result_ready = 1'b0;
	logic signed [VW-1:0] result_a;
	logic signed [VW-1:0] result_b;
	logic signed [VW-1:0] result_c;
	logic                 saturated;

	rotation_board board = new();
	bit            no_gaps = 1'b0;

	always #10 clk = ~clk;

	ecef_ned_velocity_rotator #(.VEL_WIDTH(VW), .TRIG_FRAC_BITS(TF)) uut (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_ready(item_ready),
		.opcode(opcode), .latitude(latitude), .longitude(longitude),
		.origin_vx(origin_vx), .origin_vy(origin_vy), .origin_vz(origin_vz),
		.second_a(second_a), .second_b(second_b), .second_c(second_c),
		.result_valid(result_valid), .result_ready(result_ready),
		.result_a(result_a), .result_b(result_b), .result_c(result_c),
		.saturated(saturated)
	);

	task automatic send_item(input rot_item_t it);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		opcode <= it.op;
		latitude <= it.lat;
		longitude <= it.lon;
		origin_vx <= it.org[0];
		origin_vy <= it.org[1];
		origin_vz <= it.org[2];
		second_a <= it.sec[0];
		second_b <= it.sec[1];
		second_c <= it.sec[2];
		do @(posedge clk); while (!item_ready);
		board.note_item(it);
	endtask

	function automatic logic [31:0] rand_vel();
		case ($urandom_range(0, 7))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return $urandom_range(0, 2000000) - 1000000;
			default: return $urandom;
		endcase
	endfunction

	function automatic rot_item_t rand_item();
		rot_item_t it;
		longint    lt;
		it.op = evr_pkg::op_t'($urandom_range(0, 1));
		case ($urandom_range(0, 9))
			0: lt = 64'sd1073741824;
			1: lt = -64'sd1073741824;
			2: lt = longint'($urandom_range(0, 2)) - 1;
			default: lt = longint'($urandom_range(0, 32'h8000_0000)) - 64'sd1073741824;
		endcase
		it.lat = lt[31:0];
		it.lon = $urandom;
		for (int i = 0; i < 3; i++) begin
			it.org[i] = rand_vel();
			it.sec[i] = rand_vel();
		end
		return it;
	endfunction

	function automatic rot_item_t make_item(input evr_pkg::op_t op, input logic [31:0] lat,
			input logic [31:0] lon, input logic [31:0] o, input logic [31:0] s);
		rot_item_t it;
		it.op = op;
		it.lat = lat;
		it.lon = lon;
		for (int i = 0; i < 3; i++) begin
			it.org[i] = o;
			it.sec[i] = s;
		end
		return it;
	endfunction

	// receiver: random stall before each result, checked on the accepting edge
	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			gap = no_gaps ? 0 : $urandom_range(0, 3);
			if (gap > 0) begin
				result_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			result_ready <= 1'b1;
			do @(posedge clk); while (!result_valid);
			board.check_result(result_a, result_b, result_c, saturated);
		end
	end

	initial begin
		rot_item_t it;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// angle extremes, octant boundary, difference and result saturation
		send_item(make_item(evr_pkg::OP_TO_VIEW, 32'h4000_0000, 32'h8000_0000,
			32'h0001_0000, 32'h0003_0000));
		send_item(make_item(evr_pkg::OP_TO_VIEW, 32'hC000_0000, 32'h7FFF_FFFF, 32'h0,
			32'h0001_0000));
		send_item(make_item(evr_pkg::OP_FROM_VIEW, 32'h0, 32'h0, 32'h0, 32'h0001_0000));
		send_item(make_item(evr_pkg::OP_FROM_VIEW, 32'h2000_0000, 32'h4000_0000,
			32'h1234_5678, 32'hFFFF_0000));
		send_item(make_item(evr_pkg::OP_TO_VIEW, 32'h2000_0001, 32'h2000_0000, 32'h0, 32'h0));
		send_item(make_item(evr_pkg::OP_TO_VIEW, 32'h1FFF_FFFF, 32'hE000_0001, 32'h0,
			32'h7FFF_FFFF));
		send_item(make_item(evr_pkg::OP_TO_VIEW, 32'h1000_0000, 32'h1000_0000,
			32'h8000_0000, 32'h7FFF_FFFF));
		send_item(make_item(evr_pkg::OP_TO_VIEW, 32'hF000_0000, 32'h5000_0000,
			32'h7FFF_FFFF, 32'h8000_0000));
		send_item(make_item(evr_pkg::OP_FROM_VIEW, 32'h1000_0000, 32'h3000_0000,
			32'h7FFF_FFFF, 32'h7FFF_FFFF));
		send_item(make_item(evr_pkg::OP_FROM_VIEW, 32'hE000_0000, 32'hB000_0000,
			32'h8000_0000, 32'h8000_0000));
		send_item(make_item(evr_pkg::OP_FROM_VIEW, 32'h4000_0000, 32'hFFFF_FFFF,
			32'hFFFF_FFFF, 32'h0000_0001));
		send_item(make_item(evr_pkg::OP_TO_VIEW, 32'hFFFF_FFFF, 32'h0000_0001,
			32'h0000_8000, 32'hFFFF_8000));
		send_item(make_item(evr_pkg::OP_FROM_VIEW, 32'h0000_0001, 32'hC000_0000, 32'h0,
			32'h7FFF_FFFF));
		send_item(make_item(evr_pkg::OP_TO_VIEW, 32'h3FFF_FFFF, 32'h4000_0001,
			32'h8000_0000, 32'h0));

		for (int n = 0; n < 2000; n++) begin
			// stretches of back-to-back traffic with no stalls
			if (n % 400 == 100) no_gaps = 1'b1;
			if (n % 400 == 250) no_gaps = 1'b0;
			if (n == 1000) begin
				item_valid <= 1'b0;
				wait (board.pending.size() == 0);
				@(posedge clk);
			end
			send_item(rand_item());
		end
		item_valid <= 1'b0;

		wait (board.pending.size() == 0);
		repeat (100) @(posedge clk);
		$display("covered %0d to-view and %0d from-view rotations, %0d results checked",
			board.n_view, board.n_back, board.n_checked);
		$display("%0d results expected saturated", board.n_sat);
		if (board.errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("timeout with %0d results outstanding", board.pending.size());
		$display("DONE: errors detected");
		$finish;
	end

endmodule
